FILE: sv/console_line_editor_macros.svh
// Assertion macros shared by the console line editor checker.
`ifndef CONSOLE_LINE_EDITOR_MACROS_SVH
`define CONSOLE_LINE_EDITOR_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define CLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cle_pkg.sv
// Types, codes and sizes shared by the console line editor modules.
package cle_pkg;

  localparam int LINE_BYTES = 64;
  localparam int CNT_W      = $clog2(LINE_BYTES);

  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 6;
  localparam int ACT_W  = 3;
  localparam int LEN_W  = 6;
  localparam int MODE_W = 2;

  // Commands
  localparam logic [CMD_W-1:0] CMD_RECV    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  // Editor modes
  localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COLLECT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READY   = 2'd2;

  // Echo actions
  localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ECHO   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CRLF   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ERASE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PROMPT = 3'd4;

  // Characters
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
  localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_CTRL_U = 8'h15;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TILDE  = 8'h7E;

  typedef struct packed {
    logic [ACT_W-1:0]  echo_action;
    logic [BYTE_W-1:0] echo_byte;
    logic [LEN_W-1:0]  erase_count;
    logic              line_ready;
    logic [LEN_W-1:0]  line_length;
    logic [BYTE_W-1:0] read_data;
    logic              dropped;
  } result_t;

endpackage

FILE: sv/cle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; hold data when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/cle_edit.sv
// Input register, editor state and per-word line edit decision.
module cle_edit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [cle_pkg::CMD_W-1:0]   command,
  input  logic [cle_pkg::BYTE_W-1:0]  rx_byte,
  input  logic [cle_pkg::IDX_W-1:0]   read_index,
  input  logic                        advance,
  output logic                        s1_valid,
  output cle_pkg::result_t            res
);
  import cle_pkg::*;

  localparam int CMP_W = CNT_W + IDX_W + 1;

  logic [CMD_W-1:0]  s1_cmd;
  logic [BYTE_W-1:0] s1_byte;
  logic [IDX_W-1:0]  s1_idx;

  logic [MODE_W-1:0] mode, mode_next;
  logic [CNT_W-1:0]  stored_count, stored_count_next;

  logic              we;
  logic [BYTE_W-1:0] ram_rdata;
  logic              byp_hit;
  logic [BYTE_W-1:0] byp_data;
  logic [BYTE_W-1:0] line_byte;
  logic              fire;

  assign fire = s1_valid && advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd  <= command;
      s1_byte <= rx_byte;
      s1_idx  <= read_index;
    end
  end

  // Line store; read issued as the word enters, write when it leaves
  cle_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_BYTES)
  ) u_line_store (
    .clk   (clk),
    .we    (we),
    .waddr (stored_count),
    .wdata (s1_byte),
    .re    (accept),
    .raddr (CNT_W'(read_index)),
    .rdata (ram_rdata)
  );

  // Forward a write that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (accept) begin
      byp_hit  <= we && (stored_count == CNT_W'(read_index));
      byp_data <= s1_byte;
    end
  end

  assign line_byte = byp_hit ? byp_data : ram_rdata;

  // Edit decision for the word in the input register
  always_comb begin
    mode_next         = mode;
    stored_count_next = stored_count;
    we                = 1'b0;
    res               = '0;
    case (s1_cmd)
      CMD_RELEASE: begin
        stored_count_next = '0;
        mode_next         = MODE_COLLECT;
        res.echo_action   = ACT_PROMPT;
      end
      CMD_READ: begin
        if (CMP_W'(s1_idx) < CMP_W'(stored_count) && CMP_W'(s1_idx) < CMP_W'(LINE_BYTES)) begin
          res.read_data = line_byte;
        end
      end
      CMD_RECV: begin
        if (mode != MODE_COLLECT) begin
          res.dropped = 1'b1;
        end else if (s1_byte == CH_CR) begin
          res.echo_action = ACT_CRLF;
          mode_next       = MODE_READY;
        end else if (s1_byte == CH_BS || s1_byte == CH_DEL) begin
          if (stored_count != '0) begin
            stored_count_next = stored_count - CNT_W'(1);
            res.echo_action   = ACT_ERASE;
            res.erase_count   = LEN_W'(1);
          end
        end else if (s1_byte == CH_CTRL_U) begin
          if (stored_count != '0) begin
            stored_count_next = '0;
            res.echo_action   = ACT_ERASE;
            res.erase_count   = LEN_W'(stored_count);
          end
        end else if (s1_byte >= CH_SPACE && s1_byte <= CH_TILDE) begin
          if (stored_count < CNT_W'(LINE_BYTES - 1)) begin
            we                = fire;
            stored_count_next = stored_count + CNT_W'(1);
            res.echo_action   = ACT_ECHO;
            res.echo_byte     = s1_byte;
          end
        end
      end
      default: begin
        // unused command: no operation
      end
    endcase
    res.line_ready  = (mode_next == MODE_READY);
    res.line_length = LEN_W'(stored_count_next);
  end

  // Commit state as the word leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      stored_count <= '0;
    end else if (fire) begin
      mode         <= mode_next;
      stored_count <= stored_count_next;
    end
  end

endmodule

FILE: sv/console_line_editor.sv
// Top level of the serial console line editor.
//
// Input channel: in_valid/in_ready carry one command word (command, rx_byte,
// read_index). Output channel: out_valid/out_ready carry one result word per
// command (echo_action, echo_byte, erase_count, line_ready, line_length,
// read_data, dropped).
// A result passes the input register, then the output register; while the
// receiver stalls, the word waits in the input register until the output
// register is free.
// Throughput: one command per cycle unless the receiver stalls; the edit
// state and the 64-byte line store (one write and one registered read per
// cycle) are updated as each word passes the input register.
// Reset clears both pipeline registers, empties the line and puts the editor
// in idle mode, where received bytes are dropped until a release command.
// When the receiver stalls, the output word holds and the input register
// keeps its word; a new word is still taken while the input register is
// empty or moving on.
module console_line_editor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cle_pkg::CMD_W-1:0]   command,
  input  logic [cle_pkg::BYTE_W-1:0]  rx_byte,
  input  logic [cle_pkg::IDX_W-1:0]   read_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cle_pkg::ACT_W-1:0]   echo_action,
  output logic [cle_pkg::BYTE_W-1:0]  echo_byte,
  output logic [cle_pkg::LEN_W-1:0]   erase_count,
  output logic                        line_ready,
  output logic [cle_pkg::LEN_W-1:0]   line_length,
  output logic [cle_pkg::BYTE_W-1:0]  read_data,
  output logic                        dropped
);
  import cle_pkg::*;

  logic    s1_valid;
  logic    advance;
  logic    accept;
  result_t res;
  result_t out_res;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  cle_edit u_edit (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .command    (command),
    .rx_byte    (rx_byte),
    .read_index (read_index),
    .advance    (advance),
    .s1_valid   (s1_valid),
    .res        (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_res <= res;
    end
  end

  assign echo_action = out_res.echo_action;
  assign echo_byte   = out_res.echo_byte;
  assign erase_count = out_res.erase_count;
  assign line_ready  = out_res.line_ready;
  assign line_length = out_res.line_length;
  assign read_data   = out_res.read_data;
  assign dropped     = out_res.dropped;

endmodule

FILE: sv/cle_checker.sv
// Port-level checker for the console line editor, bound to the top level.
`include "console_line_editor_macros.svh"

module cle_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cle_pkg::ACT_W-1:0]   echo_action,
  input logic [cle_pkg::BYTE_W-1:0]  echo_byte,
  input logic [cle_pkg::LEN_W-1:0]   erase_count,
  input logic                        line_ready,
  input logic [cle_pkg::LEN_W-1:0]   line_length,
  input logic [cle_pkg::BYTE_W-1:0]  read_data,
  input logic                        dropped
);
  import cle_pkg::*;

  // A stalled result word holds
  `CLE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(echo_action) && $stable(line_length) && $stable(read_data), "stalled result changed")

  // A dropped byte makes no echo
  `CLE_ASSERT_NOW(a_drop_quiet, clk, rst, out_valid && dropped, echo_action == ACT_NONE && !line_ready == !line_ready, "dropped byte produced an action")

  // A prompt leaves an empty line in collect mode
  `CLE_ASSERT_NOW(a_prompt_empty, clk, rst, out_valid && echo_action == ACT_PROMPT, line_length == '0 && !line_ready, "prompt without empty line")

  // An echo always stores a byte
  `CLE_ASSERT_NOW(a_echo_stored, clk, rst, out_valid && echo_action == ACT_ECHO, line_length != '0 && echo_byte >= CH_SPACE && echo_byte <= CH_TILDE, "echo without stored byte")

  // An erase has a nonzero count
  `CLE_ASSERT_NOW(a_erase_count, clk, rst, out_valid && echo_action == ACT_ERASE, erase_count != '0, "erase with zero count")

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);

FILE: verif/tb_console_line_editor.sv
// Self-checking testbench for the serial console line editor.
module tb_console_line_editor;
  import cle_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_LEN   = 200;
  localparam int REPORT_MAX = 10;

  // Receiver stall patterns
  localparam int RX_ALWAYS   = 0;
  localparam int RX_RANDOM   = 1;
  localparam int RX_PERIODIC = 2;
  localparam int RX_CLUMPED  = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  command    = CMD_RECV;
  logic [BYTE_W-1:0] rx_byte    = '0;
  logic [IDX_W-1:0]  read_index = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [ACT_W-1:0]  echo_action;
  logic [BYTE_W-1:0] echo_byte;
  logic [LEN_W-1:0]  erase_count;
  logic              line_ready;
  logic [LEN_W-1:0]  line_length;
  logic [BYTE_W-1:0] read_data;
  logic              dropped;

  console_line_editor dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .rx_byte(rx_byte), .read_index(read_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .echo_action(echo_action), .echo_byte(echo_byte), .erase_count(erase_count),
    .line_ready(line_ready), .line_length(line_length), .read_data(read_data),
    .dropped(dropped)
  );

  always #5 clk = ~clk;

  // Shadow copy of the editor state
  logic [MODE_W-1:0] ed_mode;
  int                ed_count;
  logic [BYTE_W-1:0] ed_line [LINE_BYTES];

  result_t expected_results [$];

  int burst_left  = 0;
  int max_gap     = 0;
  int rx_mode     = RX_ALWAYS;
  int rx_phase    = 0;
  int hold_cycles = 0;
  int idle_cycles = 0;
  int error_count = 0;
  int words_sent  = 0;
  int words_checked = 0;
  int drops_seen  = 0;
  int erases_seen = 0;
  int echoes_seen = 0;

  // Apply one command to the shadow state and return the word it should produce
  function automatic result_t edit_line(input logic [CMD_W-1:0] cmd,
                                        input logic [BYTE_W-1:0] ch,
                                        input logic [IDX_W-1:0] idx);
    result_t r;
    r = '0;
    case (cmd)
      CMD_RELEASE: begin
        ed_count = 0;
        ed_mode = MODE_COLLECT;
        r.echo_action = ACT_PROMPT;
      end
      CMD_READ: begin
        if (int'(idx) < ed_count) r.read_data = ed_line[idx];
      end
      CMD_RECV: begin
        if (ed_mode != MODE_COLLECT) begin
          r.dropped = 1'b1;
        end else if (ch == CH_CR) begin
          r.echo_action = ACT_CRLF;
          ed_mode = MODE_READY;
        end else if (ch == CH_BS || ch == CH_DEL) begin
          if (ed_count > 0) begin
            ed_count--;
            r.echo_action = ACT_ERASE;
            r.erase_count = LEN_W'(1);
          end
        end else if (ch == CH_CTRL_U) begin
          if (ed_count > 0) begin
            r.echo_action = ACT_ERASE;
            r.erase_count = LEN_W'(ed_count);
            ed_count = 0;
          end
        end else if (ch >= CH_SPACE && ch <= CH_TILDE) begin
          if (ed_count < LINE_BYTES - 1) begin
            ed_line[ed_count] = ch;
            ed_count++;
            r.echo_action = ACT_ECHO;
            r.echo_byte = ch;
          end
        end
      end
      default: ;
    endcase
    r.line_ready  = (ed_mode == MODE_READY);
    r.line_length = LEN_W'(ed_count);
    return r;
  endfunction

  // Offer one word, honoring the burst/gap pattern, and record its prediction
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] ch,
                           input logic [IDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    command    <= cmd;
    rx_byte    <= ch;
    read_index <= idx;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    words_sent++;
    expected_results.push_back(edit_line(cmd, ch, idx));
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_drops;
    rx_mode = RX_ALWAYS;
    max_gap = 0;
    send_word(CMD_RECV, "A", 6'd0);
    send_word(CMD_RECV, 8'h00, 6'd63);
    send_word(CMD_READ, 8'hFF, 6'd0);
    send_word(CMD_UNUSED, 8'hFF, 6'd63);
  endtask

  task automatic test_basic_edits;
    rx_mode = RX_RANDOM;
    max_gap = 3;
    send_word(CMD_RELEASE, 8'h00, 6'd0);
    send_word(CMD_RECV, CH_SPACE, 6'd0);
    send_word(CMD_RECV, CH_TILDE, 6'd0);
    send_word(CMD_RECV, "Q", 6'd0);
    send_word(CMD_READ, 8'h00, 6'd0);
    send_word(CMD_READ, 8'h00, 6'd1);
    send_word(CMD_READ, 8'h00, 6'd63);
    send_word(CMD_RECV, CH_DEL, 6'd0);
    send_word(CMD_RECV, CH_BS, 6'd0);
    // control and high bytes are ignored while collecting
    send_word(CMD_RECV, 8'h1F, 6'd0);
    send_word(CMD_RECV, 8'h80, 6'd0);
    send_word(CMD_RECV, 8'hFF, 6'd0);
    send_word(CMD_RECV, CH_CTRL_U, 6'd0);
    // erase on an empty line does nothing
    send_word(CMD_RECV, CH_BS, 6'd0);
    send_word(CMD_RECV, CH_DEL, 6'd0);
    send_word(CMD_RECV, CH_CTRL_U, 6'd0);
    send_word(CMD_RECV, "z", 6'd0);
    send_word(CMD_RECV, CH_CR, 6'd0);
    send_word(CMD_RECV, "x", 6'd0);
    send_word(CMD_READ, 8'h00, 6'd0);
    send_word(CMD_UNUSED, 8'h00, 6'd0);
    send_word(CMD_RELEASE, 8'hFF, 6'd63);
  endtask

  // Fill the line with random printable bytes until it refuses more
  task automatic test_line_full;
    rx_mode = RX_PERIODIC;
    max_gap = 2;
    send_word(CMD_RELEASE, 8'h00, 6'd0);
    repeat (LINE_BYTES + 2)
      send_word(CMD_RECV, BYTE_W'($urandom_range(CH_SPACE, CH_TILDE)), IDX_W'($urandom));
    send_word(CMD_READ, 8'h00, 6'(LINE_BYTES - 2));
    send_word(CMD_READ, 8'h00, 6'(LINE_BYTES - 1));
    send_word(CMD_RECV, CH_CTRL_U, 6'd0);
    send_word(CMD_READ, 8'h00, 6'd0);
  endtask

  // Mostly well-formed editing with random content, some noise
  task automatic run_sessions(input int count);
    int roll;
    logic [BYTE_W-1:0] ch;
    logic [IDX_W-1:0] idx;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      idx = IDX_W'($urandom);
      if (roll < 8) begin
        send_word(CMD_RELEASE, BYTE_W'($urandom), idx);
      end else if (roll < 14) begin
        send_word(CMD_W'($urandom), BYTE_W'($urandom), idx);
      end else if (roll < 18) begin
        send_word(CMD_RECV, CH_CR, idx);
      end else if (roll < 30) begin
        if (roll < 26) idx = IDX_W'($urandom_range(0, ed_count));
        send_word(CMD_READ, BYTE_W'($urandom), idx);
      end else if (roll < 38) begin
        send_word(CMD_RECV, roll[0] ? CH_BS : CH_DEL, idx);
      end else if (roll < 40) begin
        send_word(CMD_RECV, CH_CTRL_U, idx);
      end else if (roll < 44) begin
        ch = roll[0] ? BYTE_W'($urandom_range(0, 8'h1F)) : BYTE_W'($urandom_range(8'h7F, 8'hFF));
        send_word(CMD_RECV, ch, idx);
      end else begin
        send_word(CMD_RECV, BYTE_W'($urandom_range(CH_SPACE, CH_TILDE)), idx);
      end
    end
  endtask

  task automatic test_random_sessions;
    rx_mode = RX_ALWAYS;
    max_gap = 0;
    run_sessions(80);
    rx_mode = RX_RANDOM;
    max_gap = 6;
    run_sessions(130);
    rx_mode = RX_CLUMPED;
    max_gap = 10;
    run_sessions(130);
    rx_mode = RX_PERIODIC;
    max_gap = 1;
    run_sessions(100);
  endtask

  // Stall the receiver long enough that the editor blocks its input
  task automatic test_backpressure;
    rx_mode = RX_ALWAYS;
    max_gap = 0;
    hold_cycles = HOLD_LEN;
    run_sessions(40);
    drain;
    rx_mode = RX_RANDOM;
    run_sessions(20);
  endtask

  // Receiver: a long hold when requested, otherwise the current stall pattern
  always @(negedge clk) begin
    rx_phase++;
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      case (rx_mode)
        RX_RANDOM:   out_ready <= ($urandom_range(0, 2) != 0);
        RX_PERIODIC: out_ready <= (rx_phase % 5) < 3;
        RX_CLUMPED:  out_ready <= (rx_phase % 16) >= 6 || ($urandom_range(0, 3) == 0);
        default:     out_ready <= 1'b1;
      endcase
    end
  end

  // Check each result word against the oldest prediction
  always @(posedge clk) begin : result_check
    result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {echo_action, echo_byte, erase_count, line_ready, line_length, read_data,
             dropped};
      words_checked++;
      if (dropped) drops_seen++;
      if (echo_action == ACT_ERASE) erases_seen++;
      if (echo_action == ACT_ECHO) echoes_seen++;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("unexpected result word: act=%0d byte=%h cnt=%0d rdy=%b len=%0d rd=%h drop=%b",
                   got.echo_action, got.echo_byte, got.erase_count, got.line_ready,
                   got.line_length, got.read_data, got.dropped);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= REPORT_MAX) begin
            $display("mismatch at word %0d:", words_checked);
            $display("  expected act=%0d byte=%h cnt=%0d rdy=%b len=%0d rd=%h drop=%b",
                     want.echo_action, want.echo_byte, want.erase_count, want.line_ready,
                     want.line_length, want.read_data, want.dropped);
            $display("  actual   act=%0d byte=%h cnt=%0d rdy=%b len=%0d rd=%h drop=%b",
                     got.echo_action, got.echo_byte, got.erase_count, got.line_ready,
                     got.line_length, got.read_data, got.dropped);
          end
        end
      end
    end
  end

  // Watchdog: end the run if no word moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word accepted for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, expected_results.size());
      $display("console_line_editor test failed");
      $finish;
    end
  end

  initial begin
    ed_mode  = MODE_IDLE;
    ed_count = 0;
    foreach (ed_line[i]) ed_line[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_drops;
    test_basic_edits;
    test_line_full;
    test_random_sessions;
    test_backpressure;

    drain;
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0) error_count++;
    $display("covered %0d commands: %0d echoes, %0d erasures, %0d dropped bytes checked",
             words_sent, echoes_seen, erases_seen, drops_seen);
    $display("line-full, empty-erase, idle drops, long output stall; %0d failures",
             error_count);
    if (error_count == 0) begin
      $display("console_line_editor test passed");
    end else begin
      $display("console_line_editor test failed");
    end
    $finish;
  end

endmodule
